// ===== rtl/tsp_pkg.sv =====
// Shared package for the trapezoid servo profiler: types, codes and constants.
// Used by the divider, the square-root unit, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

    // Block dimensions.
    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SCALE        = 100;
    localparam int DW           = 32;
    localparam int CFG_AW       = 5;

    // Reciprocal of the scale factor: for any 32-bit x, x / SCALE equals
    // (x * SCALE_RECIP) >> SCALE_SHIFT.
    localparam int SCALE_SHIFT = 32 + $clog2(SCALE);
    localparam logic [32:0] SCALE_RECIP =
        33'(((64'd1 << SCALE_SHIFT) + 64'(SCALE) - 64'd1) / 64'(SCALE));

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MOVE   = 2'd1;
    localparam logic [1:0] CMD_DIRECT = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Status codes of a result transaction.
    localparam logic [2:0] STAT_TICK    = 3'd0;
    localparam logic [2:0] STAT_BUSY    = 3'd1;
    localparam logic [2:0] STAT_NOOP    = 3'd2;
    localparam logic [2:0] STAT_SHORT   = 3'd3;
    localparam logic [2:0] STAT_SCALED  = 3'd4;
    localparam logic [2:0] STAT_TRAP    = 3'd5;
    localparam logic [2:0] STAT_DIRECT  = 3'd6;

    // Configuration register indexes (word address).
    localparam logic [2:0] REG_MIN_STEPS    = 3'd0;
    localparam logic [2:0] REG_MAX_ACCEL    = 3'd1;
    localparam logic [2:0] REG_MAX_VELOCITY = 3'd2;
    localparam logic [2:0] REG_RANGE_MIN    = 3'd3;
    localparam logic [2:0] REG_RANGE_MAX    = 3'd4;
    localparam logic [2:0] REG_CENTER       = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] MIN_STEPS_RESET    = 16'd10;
    localparam logic [23:0] MAX_ACCEL_RESET    = 24'd100;
    localparam logic [23:0] MAX_VELOCITY_RESET = 24'd2000;
    localparam logic [15:0] RANGE_MIN_RESET    = 16'd500;
    localparam logic [15:0] RANGE_MAX_RESET    = 16'd2500;
    localparam logic [15:0] CENTER_RESET       = 16'd1500;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  channel;
        logic [15:0] target;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  channel_out;
        logic [15:0] position;
        logic [2:0]  status;
        logic        moving;
        logic        last;
    } out_item_t;

    // Per-channel motion record held in the state memory.
    typedef struct packed {
        logic [15:0] position;
        logic [31:0] velocity;
        logic [31:0] accel;
        logic [15:0] step_count;
        logic [15:0] accel_end;
        logic [15:0] cruise_end;
        logic [15:0] decel_end;
        logic        running;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);
    localparam chan_entry_t ENTRY_RESET = '{position: CENTER_RESET, default: '0};

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV_N,
        S_DIV_ACC,
        S_DIV_T,
        S_SQRT_T,
        S_BRANCH,
        S_DIV_A,
        S_SQRT_D,
        S_MUL_PH,
        S_DIV_C,
        S_MUL_M,
        S_START,
        S_TICK_MUL,
        S_TICK_ADD,
        S_EMIT
    } fsm_state_t;

    // Clamp a wide product to 32 bits; used for divisors against small dividends.
    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (|v[63:32]) ? '1 : v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tsp_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle; a zero divisor acts as one.
// Depends on tsp_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module tsp_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [tsp_pkg::DW-1:0] dividend,
    input  wire logic [tsp_pkg::DW-1:0] divisor,
    output logic                     done,
    output logic [tsp_pkg::DW-1:0]   quotient
);
    import tsp_pkg::*;

    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;

    // One shift-and-subtract step per cycle.
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = (divisor == '0) ? DW'(1) : divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/tsp_isqrt.sv =====
// Floor square root by the digit-by-digit method, two radicand bits per cycle.
// Depends on tsp_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module tsp_isqrt (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [tsp_pkg::DW-1:0] value,
    output logic                        done,
    output logic [tsp_pkg::DW/2-1:0]    root
);
    import tsp_pkg::*;

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] res_reg, res_next;
    logic [DW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW-1:0] trial;

    // One result bit per cycle, walking the probe bit down by two places.
    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start) begin
            rem_next  = value;
            res_next  = '0;
            bit_next  = DW'(1) << (DW - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == DW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[DW/2-1:0];

endmodule

`default_nettype wire

// ===== rtl/trapezoid_servo_profiler_unit.sv =====
// Top level of the trapezoid servo profiler: configuration port, sequencer and output register.
// Depends on tsp_pkg, tsp_ram, tsp_divider and tsp_isqrt.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one motion record per servo channel in a small synchronous
// memory and serves one input transaction at a time: it reads the record,
// updates it and writes it back while it delivers the results. A direct set
// or a rejected move passes from acceptance through read, load and result
// back to idle. A tick takes each channel in turn through read, load and
// result; for a channel that takes a step the velocity is first scaled down
// by a reciprocal multiplication and then added to the position. A planned
// move is set by the shared divider and the square-root unit: three to five
// divisions and one or two roots. An unused command is dropped without a
// result. Results wait in an output register; a stalled result channel holds
// the sequencer until the result is taken. Records read as their reset value
// until first written, so no clearing pass follows reset.
module trapezoid_servo_profiler_unit (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tsp_pkg::in_item_t    s_data,
    // Result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tsp_pkg::out_item_t        m_data,
    // Configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [tsp_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tsp_pkg::*;

    // Configuration registers.
    logic [15:0] min_steps_reg;
    logic [23:0] max_accel_reg;
    logic [23:0] max_velocity_reg;
    logic [15:0] range_min_reg;
    logic [15:0] range_max_reg;
    logic [15:0] center_reg;

    // Sequencer state.
    fsm_state_t       state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [CH_W-1:0]  idx_reg, idx_next;
    logic [15:0]      tgt_reg, tgt_next;
    chan_entry_t      ent_reg, ent_next;
    logic [23:0]      n_reg, n_next;
    logic [23:0]      acc_reg, acc_next;
    logic [DW-1:0]    dist_reg, dist_next;
    logic             down_reg, down_next;
    logic [15:0]      k_reg, k_next;
    logic [15:0]      steps_reg, steps_next;
    logic [DW-1:0]    a_reg, a_next;
    logic [DW-1:0]    c_reg, c_next;
    logic [63:0]      p_reg, p_next;
    logic [DW-1:0]    pn_reg, pn_next;
    logic [2:0]       status_reg, status_next;
    logic             div_issued_reg, div_issued_next;
    logic             sq_issued_reg, sq_issued_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic [NUM_CHANNELS-1:0] valid_reg, valid_next;

    // Arithmetic unit handshakes.
    logic             div_start, div_done;
    logic [DW-1:0]    div_a, div_b, div_q;
    logic             sq_start, sq_done;
    logic [DW-1:0]    sq_a;
    logic [DW/2-1:0]  sq_root;

    // Memory ports.
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_rdata;
    chan_entry_t           cur_ent;

    // Combinational helpers.
    logic             accept;
    logic             cfg_write;
    logic             out_load;
    logic [15:0]      set_pos;
    logic [15:0]      diff;
    logic             noop;
    logic             step_go;
    logic [23:0]      n_quot;
    logic [16:0]      k1;
    logic [32:0]      nc;
    logic [DW-1:0]    vel_mag;
    logic [DW-1:0]    vel_quot;
    logic [DW-1:0]    delta;
    logic [DW-1:0]    rest;
    logic             last_chan;

    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_ready   = (state_reg == S_IDLE);
    assign pready    = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || m_ready);
    assign ram_we    = out_load;
    assign cur_ent   = valid_reg[idx_reg] ? chan_entry_t'(ram_rdata) : ENTRY_RESET;
    assign last_chan = (32'(idx_reg) == NUM_CHANNELS - 1);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_steps_reg    <= MIN_STEPS_RESET;
            max_accel_reg    <= MAX_ACCEL_RESET;
            max_velocity_reg <= MAX_VELOCITY_RESET;
            range_min_reg    <= RANGE_MIN_RESET;
            range_max_reg    <= RANGE_MAX_RESET;
            center_reg       <= CENTER_RESET;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_MIN_STEPS:    min_steps_reg    <= pwdata[15:0];
                REG_MAX_ACCEL:    max_accel_reg    <= pwdata[23:0];
                REG_MAX_VELOCITY: max_velocity_reg <= pwdata[23:0];
                REG_RANGE_MIN:    range_min_reg    <= pwdata[15:0];
                REG_RANGE_MAX:    range_max_reg    <= pwdata[15:0];
                REG_CENTER:       center_reg       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        case (paddr[4:2])
            REG_MIN_STEPS:    prdata = 32'(min_steps_reg);
            REG_MAX_ACCEL:    prdata = 32'(max_accel_reg);
            REG_MAX_VELOCITY: prdata = 32'(max_velocity_reg);
            REG_RANGE_MIN:    prdata = 32'(range_min_reg);
            REG_RANGE_MAX:    prdata = 32'(range_max_reg);
            REG_CENTER:       prdata = 32'(center_reg);
            default:          prdata = '0;
        endcase
    end

    // Channel record memory.
    tsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ent_reg),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    tsp_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    tsp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sq_a),
        .done    (sq_done),
        .root    (sq_root)
    );

    // State register and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            div_issued_reg <= 1'b0;
            sq_issued_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            div_issued_reg <= div_issued_next;
            sq_issued_reg  <= sq_issued_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
        end
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        tgt_reg      <= tgt_next;
        ent_reg      <= ent_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        dist_reg     <= dist_next;
        down_reg     <= down_next;
        k_reg        <= k_next;
        steps_reg    <= steps_next;
        a_reg        <= a_next;
        c_reg        <= c_next;
        p_reg        <= p_next;
        pn_reg       <= pn_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        tgt_next     = tgt_reg;
        ent_next     = ent_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        dist_next    = dist_reg;
        down_next    = down_reg;
        k_next       = k_reg;
        steps_next   = steps_reg;
        a_next       = a_reg;
        c_next       = c_reg;
        p_next       = p_reg;
        pn_next      = pn_reg;
        status_next  = status_reg;
        valid_next   = valid_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

        div_start = 1'b0;
        div_a     = '0;
        div_b     = DW'(1);
        sq_start  = 1'b0;
        sq_a      = '0;

        set_pos = tgt_reg;
        noop    = 1'b0;
        diff    = '0;
        step_go = 1'b0;
        n_quot  = div_q[23:0];
        k1      = 17'(k_reg) + 17'd1;
        nc      = 33'(n_reg) + 33'(c_reg);
        vel_mag = ent_reg.velocity[31] ? (DW'(0) - ent_reg.velocity) : ent_reg.velocity;
        vel_quot = DW'(p_reg >> SCALE_SHIFT);
        delta   = ent_reg.velocity[31] ? (DW'(0) - vel_quot) : vel_quot;
        rest    = ({32'b0, dist_reg} >= p_reg) ? (dist_reg - p_reg[DW-1:0]) : '0;

        case (state_reg)
            // Wait for a transaction; unused commands and channels are dropped.
            S_IDLE: begin
                if (accept) begin
                    cmd_next = s_data.command;
                    tgt_next = s_data.target;
                    if (s_data.command == CMD_TICK) begin
                        idx_next   = '0;
                        state_next = S_READ;
                    end else if (s_data.command != CMD_NONE &&
                                 32'(s_data.channel) < NUM_CHANNELS) begin
                        idx_next   = CH_W'(s_data.channel);
                        state_next = S_READ;
                    end
                end
            end

            // Memory address settles; data arrives next cycle.
            S_READ: begin
                state_next = S_LOAD;
            end

            // Take the record and decide what the command does with it.
            S_LOAD: begin
                ent_next = cur_ent;
                case (cmd_reg)
                    CMD_DIRECT: begin
                        ent_next.position = tgt_reg;
                        status_next = STAT_DIRECT;
                        state_next  = S_EMIT;
                    end
                    CMD_MOVE: begin
                        if (tgt_reg > range_max_reg) begin
                            set_pos = range_max_reg;
                        end else if (tgt_reg < range_min_reg) begin
                            set_pos = range_min_reg;
                        end else begin
                            noop = (tgt_reg == cur_ent.position);
                        end
                        down_next = (set_pos < cur_ent.position);
                        diff = (set_pos < cur_ent.position) ? (cur_ent.position - set_pos)
                                                            : (set_pos - cur_ent.position);
                        dist_next = DW'(32'(diff) * SCALE);
                        if (cur_ent.running) begin
                            status_next = STAT_BUSY;
                            state_next  = S_EMIT;
                        end else if (noop) begin
                            status_next = STAT_NOOP;
                            state_next  = S_EMIT;
                        end else begin
                            state_next = S_DIV_N;
                        end
                    end
                    default: begin
                        status_next = STAT_TICK;
                        if (cur_ent.running) begin
                            if (cur_ent.step_count < cur_ent.accel_end) begin
                                ent_next.velocity = cur_ent.velocity + cur_ent.accel;
                                step_go = 1'b1;
                            end else if (cur_ent.step_count < cur_ent.cruise_end) begin
                                step_go = 1'b1;
                            end else if (cur_ent.step_count < cur_ent.decel_end &&
                                         cur_ent.velocity != '0) begin
                                ent_next.velocity = cur_ent.velocity - cur_ent.accel;
                                step_go = 1'b1;
                            end else begin
                                ent_next.running = 1'b0;
                            end
                        end
                        state_next = step_go ? S_TICK_MUL : S_EMIT;
                    end
                endcase
            end

            // Steps of full acceleration: max_velocity / max_accel.
            S_DIV_N: begin
                div_start = !div_issued_reg;
                div_a     = DW'(max_velocity_reg);
                div_b     = DW'(max_accel_reg);
                if (div_done) begin
                    if (n_quot < 24'(min_steps_reg)) begin
                        n_next     = 24'(min_steps_reg);
                        state_next = S_DIV_ACC;
                    end else begin
                        n_next     = n_quot;
                        acc_next   = max_accel_reg;
                        state_next = S_DIV_T;
                    end
                end
            end

            // Reduced acceleration when min_steps governs.
            S_DIV_ACC: begin
                div_start = !div_issued_reg;
                div_a     = DW'(max_velocity_reg);
                div_b     = DW'(n_reg);
                if (div_done) begin
                    acc_next   = div_q[23:0];
                    state_next = S_DIV_T;
                end
            end

            // Distance over acceleration, then its square root.
            S_DIV_T: begin
                div_start = !div_issued_reg;
                div_a     = dist_reg;
                div_b     = DW'(acc_reg);
                if (div_done) begin
                    state_next = S_SQRT_T;
                end
            end

            S_SQRT_T: begin
                sq_start = !sq_issued_reg;
                sq_a     = div_q;
                if (sq_done) begin
                    k_next     = sq_root;
                    state_next = S_BRANCH;
                end
            end

            // Pick the short, scaled or trapezoid plan.
            S_BRANCH: begin
                c_next = '0;
                if (k_reg < min_steps_reg) begin
                    status_next = STAT_SHORT;
                    steps_next  = min_steps_reg;
                    p_next      = 64'(min_steps_reg) * 64'(min_steps_reg);
                    state_next  = S_DIV_A;
                end else if (24'(k_reg) < n_reg) begin
                    status_next = STAT_SCALED;
                    steps_next  = k1[15:0];
                    p_next      = 64'(k1) * 64'(k1);
                    state_next  = S_DIV_A;
                end else begin
                    status_next = STAT_TRAP;
                    steps_next  = n_reg[15:0];
                    p_next      = 64'(acc_reg) * 64'(n_reg);
                    state_next  = S_MUL_PH;
                end
            end

            // Acceleration per step: distance over the product in p_reg.
            S_DIV_A: begin
                div_start = !div_issued_reg;
                div_a     = dist_reg;
                div_b     = sat32(p_reg);
                if (div_done) begin
                    if (status_reg == STAT_SCALED && div_q == '0) begin
                        a_next     = DW'(1);
                        state_next = S_SQRT_D;
                    end else begin
                        a_next     = div_q;
                        state_next = S_START;
                    end
                end
            end

            // Scaled plan fallback: steps from the root of the distance.
            S_SQRT_D: begin
                sq_start = !sq_issued_reg;
                sq_a     = dist_reg;
                if (sq_done) begin
                    steps_next = sq_root[15:0];
                    state_next = S_START;
                end
            end

            // Distance covered while accelerating: acc * n * n.
            S_MUL_PH: begin
                pn_next    = sat32(p_reg);
                p_next     = 64'(sat32(p_reg)) * 64'(n_reg);
                state_next = S_DIV_C;
            end

            // Cruise steps from the remaining distance.
            S_DIV_C: begin
                div_start = !div_issued_reg;
                div_a     = rest;
                div_b     = pn_reg;
                if (div_done) begin
                    c_next     = div_q + DW'(1);
                    state_next = S_MUL_M;
                end
            end

            S_MUL_M: begin
                p_next     = 64'(n_reg) * 64'(nc);
                state_next = S_DIV_A;
            end

            // Load the planned motion into the record.
            S_START: begin
                ent_next.accel      = down_reg ? (DW'(0) - a_reg) : a_reg;
                ent_next.accel_end  = steps_reg;
                ent_next.cruise_end = steps_reg + c_reg[15:0];
                ent_next.decel_end  = steps_reg + c_reg[15:0] + steps_reg;
                ent_next.velocity   = '0;
                ent_next.step_count = '0;
                ent_next.running    = 1'b1;
                state_next = S_EMIT;
            end

            // Velocity magnitude times the reciprocal of the scale factor.
            S_TICK_MUL: begin
                p_next     = 64'(vel_mag) * 64'(SCALE_RECIP);
                state_next = S_TICK_ADD;
            end

            // Quotient truncated toward zero, sign restored, added to the position.
            S_TICK_ADD: begin
                ent_next.position   = ent_reg.position + delta[15:0];
                ent_next.step_count = ent_reg.step_count + 16'd1;
                state_next = S_EMIT;
            end

            // Deliver the result transaction and write the record back.
            S_EMIT: begin
                out_data_next.channel_out = 2'(idx_reg);
                out_data_next.position    = ent_reg.position;
                out_data_next.status      = status_reg;
                out_data_next.moving      = ent_reg.running;
                out_data_next.last        = (cmd_reg != CMD_TICK) || last_chan;
                if (out_load) begin
                    valid_next[idx_reg] = 1'b1;
                    if (cmd_reg == CMD_TICK && !last_chan) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    out_data_next = out_data_reg;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        div_issued_next = div_done ? 1'b0 : (div_issued_reg | div_start);
        sq_issued_next  = sq_done ? 1'b0 : (sq_issued_reg | sq_start);
    end

endmodule

`default_nettype wire

// ===== tb/tb_trapezoid_servo_profiler_unit.sv =====
// Self-checking testbench for trapezoid_servo_profiler_unit: a scoreboard class
// predicts every result transaction, plain tasks drive the channels and the APB port.
// Depends on tsp_pkg and the RTL of the block.
`timescale 1ns / 1ps

import tsp_pkg::*;

// Holds a private copy of the channel state and the configuration, predicts the
// results of each accepted command and compares them with the block's output.
class servo_scoreboard;
    logic [15:0] cfg_min_steps;
    logic [23:0] cfg_max_accel;
    logic [23:0] cfg_max_vel;
    logic [15:0] cfg_range_min;
    logic [15:0] cfg_range_max;
    logic [15:0] ch_pos   [NUM_CHANNELS];
    logic [31:0] ch_vel   [NUM_CHANNELS];
    logic [31:0] ch_acc   [NUM_CHANNELS];
    logic [15:0] ch_step  [NUM_CHANNELS];
    logic [15:0] ch_aend  [NUM_CHANNELS];
    logic [15:0] ch_cend  [NUM_CHANNELS];
    logic [15:0] ch_dend  [NUM_CHANNELS];
    logic        ch_busy  [NUM_CHANNELS];
    out_item_t   pending_results[$];
    int          mismatches;

    function new();
        cfg_min_steps = MIN_STEPS_RESET;
        cfg_max_accel = MAX_ACCEL_RESET;
        cfg_max_vel   = MAX_VELOCITY_RESET;
        cfg_range_min = RANGE_MIN_RESET;
        cfg_range_max = RANGE_MAX_RESET;
        mismatches    = 0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            ch_pos[i] = CENTER_RESET;
            ch_vel[i] = '0; ch_acc[i] = '0; ch_step[i] = '0;
            ch_aend[i] = '0; ch_cend[i] = '0; ch_dend[i] = '0;
            ch_busy[i] = 1'b0;
        end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MIN_STEPS:    cfg_min_steps = val[15:0];
            REG_MAX_ACCEL:    cfg_max_accel = val[23:0];
            REG_MAX_VELOCITY: cfg_max_vel   = val[23:0];
            REG_RANGE_MIN:    cfg_range_min = val[15:0];
            REG_RANGE_MAX:    cfg_range_max = val[15:0];
            default: ;  // The center position only matters at reset.
        endcase
    endfunction

    static function logic [63:0] quot(logic [63:0] a, logic [63:0] b);
        return a / ((b == 0) ? 64'd1 : b);
    endfunction

    // Floor square root, two bits per iteration.
    static function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void launch(int ch, logic [63:0] a, logic [63:0] steps, logic [63:0] cruise,
                         bit down);
        ch_acc[ch]  = down ? (32'd0 - a[31:0]) : a[31:0];
        ch_aend[ch] = steps[15:0];
        ch_cend[ch] = ch_aend[ch] + cruise[15:0];
        ch_dend[ch] = ch_cend[ch] + steps[15:0];
        ch_step[ch] = '0;
        ch_vel[ch]  = '0;
        ch_busy[ch] = 1'b1;
    endfunction

    // Plans a move and returns the status code it reports.
    function logic [2:0] plan_motion(int ch, logic [15:0] tgt);
        logic [63:0] cur, dest, hi, lo, span, n, acc, k, a, ph, rest, c, ms;
        bit down;
        cur  = 64'(ch_pos[ch]) * SCALE;
        dest = 64'(tgt) * SCALE;
        hi   = 64'(cfg_range_max) * SCALE;
        lo   = 64'(cfg_range_min) * SCALE;
        ms   = 64'(cfg_min_steps);
        if (ch_busy[ch]) return STAT_BUSY;
        if (dest > hi) dest = hi;
        else if (dest < lo) dest = lo;
        else if (dest == cur) return STAT_NOOP;
        down = dest < cur;
        span = down ? cur - dest : dest - cur;
        n = quot(64'(cfg_max_vel), 64'(cfg_max_accel));
        if (n < ms) begin
            n   = ms;
            acc = quot(64'(cfg_max_vel), n);
        end else begin
            acc = 64'(cfg_max_accel);
        end
        k = floor_sqrt(quot(span, acc));
        if (k < ms) begin
            a = quot(span, ms * ms);
            launch(ch, a, ms, 0, down);
            return STAT_SHORT;
        end
        if (k < n) begin
            k = k + 1;
            a = quot(span, k * k);
            if (a == 0) begin
                a = 1;
                k = floor_sqrt(span);
            end
            launch(ch, a, k, 0, down);
            return STAT_SCALED;
        end
        ph   = acc * n * n;
        rest = (span >= ph) ? span - ph : 64'd0;
        c    = quot(rest, n * acc) + 1;
        a    = quot(span, n * (n + c));
        launch(ch, a, n, c, down);
        return STAT_TRAP;
    endfunction

    function void advance_channel(int ch);
        logic [15:0] s;
        int          v;
        int          q;
        if (!ch_busy[ch]) return;
        s = ch_step[ch];
        if (s < ch_aend[ch]) ch_vel[ch] = ch_vel[ch] + ch_acc[ch];
        else if (s < ch_cend[ch]) ;
        else if (s < ch_dend[ch] && ch_vel[ch] != 0) ch_vel[ch] = ch_vel[ch] - ch_acc[ch];
        else begin
            ch_busy[ch] = 1'b0;
            return;
        end
        v = ch_vel[ch];
        q = v / SCALE;
        ch_pos[ch]  = ch_pos[ch] + q[15:0];
        ch_step[ch] = s + 16'd1;
    endfunction

    function void report(int ch, logic [2:0] st, bit is_last);
        out_item_t r;
        r.channel_out = ch[1:0];
        r.position    = ch_pos[ch];
        r.status      = st;
        r.moving      = ch_busy[ch];
        r.last        = is_last;
        pending_results.push_back(r);
    endfunction

    // Called for every accepted input transaction.
    function void note_command(in_item_t it);
        int ch;
        ch = it.channel;
        case (it.command)
            CMD_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) advance_channel(i);
                for (int i = 0; i < NUM_CHANNELS; i++) report(i, STAT_TICK, i == NUM_CHANNELS - 1);
            end
            CMD_MOVE: report(ch, plan_motion(ch, it.target), 1'b1);
            CMD_DIRECT: begin
                ch_pos[ch] = it.target;
                report(ch, STAT_DIRECT, 1'b1);
            end
            default: ;  // Unused command: no result.
        endcase
    endfunction

    // Called for every accepted result transaction.
    function void check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.channel_out !== want.channel_out || got.position !== want.position ||
            got.status !== want.status || got.moving !== want.moving ||
            got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Result mismatch: expected %p, got %p", want, got);
        end
    endfunction
endclass

module tb_trapezoid_servo_profiler_unit;
    localparam int STALL_LIMIT = 6000;
    localparam int SETTLE      = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    servo_scoreboard sb = new();
    int  idle_mode = 0;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    bit  long_hold_req = 0;
    int  quiet_cycles = 0;

    trapezoid_servo_profiler_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Receiver: random stalls per phase, plus one long hold-off on request.
    always @(negedge aclk) begin
        int hold;
        if (long_hold_req && hold == 0) begin
            hold = 600;
            long_hold_req = 0;
        end
        if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else if (idle_mode == 2) begin
            m_ready <= ($urandom_range(99) >= 75);
        end else if (idle_mode == 3) begin
            m_ready <= ($urandom_range(99) >= 37);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor and watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (!aresetn || (m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_command(in_item_t it);
        int gap;
        gap = (idle_mode == 1) ? 75 : (idle_mode == 3) ? 37 : 0;
        @(negedge aclk);
        while (gap > 0 && $urandom_range(99) < gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(it);
    endtask

    task automatic cmd(logic [1:0] c, logic [1:0] ch, logic [15:0] tgt);
        in_item_t it;
        it.command = c;
        it.channel = ch;
        it.target  = tgt;
        send_command(it);
    endtask

    // Lets every expected result arrive, then the block settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(idx) << 2;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic load_profile(logic [31:0] ms, logic [31:0] acc, logic [31:0] vel,
                                logic [31:0] lo, logic [31:0] hi, logic [31:0] ctr);
        apb_write(REG_MIN_STEPS, ms);
        apb_write(REG_MAX_ACCEL, acc);
        apb_write(REG_MAX_VELOCITY, vel);
        apb_write(REG_RANGE_MIN, lo);
        apb_write(REG_RANGE_MAX, hi);
        apb_write(REG_CENTER, ctr);
    endtask

    // Random traffic: mostly ticks and moves, with direct sets and noise.
    task automatic random_traffic(int count);
        int sel;
        logic [15:0] tgt;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if ($urandom_range(3) == 0) tgt = 16'($urandom);
            else tgt = 16'($urandom_range(2700, 300));
            if (sel < 55) cmd(CMD_TICK, 2'($urandom), 16'($urandom));
            else if (sel < 82) cmd(CMD_MOVE, 2'($urandom), tgt);
            else if (sel < 95) cmd(CMD_DIRECT, 2'($urandom), tgt);
            else cmd(CMD_NONE, 2'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset configuration.
        cmd(CMD_TICK, 2'd0, 16'h0000);
        cmd(CMD_MOVE, 2'd0, 16'd1500);      // already there
        cmd(CMD_MOVE, 2'd0, 16'hFFFF);      // clamped high, trapezoid
        cmd(CMD_MOVE, 2'd0, 16'd600);       // channel busy
        cmd(CMD_MOVE, 2'd1, 16'h0000);      // clamped low
        cmd(CMD_MOVE, 2'd2, 16'd1510);      // short distance
        cmd(CMD_MOVE, 2'd3, 16'd1600);      // scaled acceleration
        cmd(CMD_DIRECT, 2'd1, 16'hFFFF);    // direct set while moving
        cmd(CMD_NONE, 2'd3, 16'hFFFF);      // unused command
        cmd(CMD_DIRECT, 2'd2, 16'h0000);
        cmd(CMD_DIRECT, 2'd3, 16'h5555);
        for (int i = 0; i < 10; i++) cmd(CMD_TICK, 2'd3, 16'hAAAA);

        // Phase with no idling, including a long receiver hold-off and a sender pause.
        idle_mode = 0;
        random_traffic(20);
        long_hold_req = 1;
        random_traffic(30);
        drain();
        random_traffic(30);
        drain();

        // Extreme high accelerations and velocities, full range.
        load_profile(1, 24'hFFFFFF, 24'hFFFFFF, 0, 16'hFFFF, 0);
        idle_mode = 1;
        random_traffic(80);
        drain();

        // Minimum acceleration: long scaled motions in a narrow range.
        load_profile(3, 1, 24'hFFFFFF, 1000, 1020, 16'hFFFF);
        idle_mode = 2;
        random_traffic(80);
        drain();

        // Zero registers and an inverted range.
        load_profile(0, 0, 50, 2000, 1000, 7);
        idle_mode = 3;
        random_traffic(80);
        drain();

        load_profile(4, 300, 5000, 100, 60000, 1500);
        idle_mode = 0;
        random_traffic(80);
        drain();

        // Largest minimum step count.
        load_profile(16'hFFFF, 1, 1, RANGE_MIN_RESET, RANGE_MAX_RESET, CENTER_RESET);
        idle_mode = 3;
        random_traffic(60);
        drain();

        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
